// ===== rtl/airtime_duty_cycle_limiter_assert.svh =====
// Assertion macros for the airtime duty-cycle limiter checker.
`ifndef AIRTIME_DUTY_CYCLE_LIMITER_ASSERT_SVH
`define AIRTIME_DUTY_CYCLE_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ADCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adcl assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ADCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adcl assertion failed");

`endif

// ===== rtl/adcl_pkg.sv =====
package adcl_pkg;

  localparam int unsigned CreditW  = 40;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned RateW    = 16;
  localparam int unsigned PreW     = 16;
  localparam int unsigned OvhW     = 5;
  localparam int unsigned BitTimeW = 16;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned LenW     = 8;
  localparam int unsigned CfgIdxW  = 3;

  // request codes
  localparam logic [ReqW-1:0] REQ_REFILL  = 2'd0;
  localparam logic [ReqW-1:0] REQ_SEND    = 2'd1;
  localparam logic [ReqW-1:0] REQ_RESTART = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_REFILL   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CAPACITY = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PREAMBLE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OVERHEAD = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BIT_TIME = 3'd4;

  // register reset values
  localparam logic [RateW-1:0]    RST_REFILL   = 16'd2560;
  localparam logic [CreditW-1:0]  RST_CAPACITY = 40'd9216000000;
  localparam logic [PreW-1:0]     RST_PREAMBLE = 16'd32;
  localparam logic [OvhW-1:0]     RST_OVERHEAD = 5'd5;
  localparam logic [BitTimeW-1:0] RST_BIT_TIME = 16'd5120;

  typedef struct packed {
    logic [RateW-1:0]    refill_per_ms_q8;
    logic [CreditW-1:0]  capacity_q8;
    logic [PreW-1:0]     preamble_bits;
    logic [OvhW-1:0]     overhead_bytes;
    logic [BitTimeW-1:0] us_per_bit_q8;
  } adcl_cfg_t;

endpackage

// ===== rtl/adcl_calc.sv =====
module adcl_calc (
  input  adcl_pkg::adcl_cfg_t                cfg,
  input  logic [adcl_pkg::CreditW-1:0]       budget,
  input  logic [adcl_pkg::TimeW-1:0]         last_time_ms,
  input  logic [adcl_pkg::ReqW-1:0]          req_type,
  input  logic [adcl_pkg::TimeW-1:0]         now_ms,
  input  logic [adcl_pkg::LenW-1:0]          payload_len,
  input  logic                               tx_ok,
  output logic                               granted,
  output logic [adcl_pkg::CreditW-1:0]       airtime_q8,
  output logic [adcl_pkg::CreditW-1:0]       budget_nxt
);

  logic [31:0] elapsed;
  logic [47:0] refill_amt;
  logic [48:0] credit;
  logic [39:0] clamped;
  logic [8:0]  frame_bytes;
  logic [16:0] frame_bits;
  logic [32:0] airtime_raw;
  logic [39:0] airtime;
  logic        is_send;
  logic        is_restart;
  logic        fits;

  // refill: wrapped elapsed time times rate, saturated at capacity
  assign elapsed    = now_ms - last_time_ms;
  assign refill_amt = elapsed * cfg.refill_per_ms_q8;
  assign credit     = {9'd0, budget} + {1'b0, refill_amt};
  assign clamped    = (credit > {9'd0, cfg.capacity_q8}) ? cfg.capacity_q8 : credit[39:0];

  assign frame_bytes = {4'd0, cfg.overhead_bytes} + {1'b0, payload_len};
  assign frame_bits  = {1'b0, cfg.preamble_bits} + {5'd0, frame_bytes, 3'd0};
  assign airtime_raw = frame_bits * cfg.us_per_bit_q8;
  assign airtime     = {7'd0, airtime_raw};

  always_comb begin
    is_send    = 1'b0;
    is_restart = 1'b0;
    case (req_type)
      adcl_pkg::REQ_SEND:    is_send    = 1'b1;
      adcl_pkg::REQ_RESTART: is_restart = 1'b1;
      default: ;
    endcase
  end

  assign fits       = (airtime <= clamped);
  assign granted    = is_send & fits;
  assign airtime_q8 = is_send ? airtime : '0;

  always_comb begin
    if (is_restart) begin
      budget_nxt = '0;
    end else if (granted && tx_ok) begin
      budget_nxt = clamped - airtime;
    end else begin
      budget_nxt = clamped;
    end
  end

endmodule

// ===== rtl/airtime_duty_cycle_limiter.sv =====
// Pipeline: an accepted input beat is held in the input register, its result in the result register.
// Throughput: one item per cycle while the result side is not stalled; the budget loop closes through the refill
// multiply, the capacity clamp and the charge subtract.
// Reset (rst_n low, synchronous): both stages empty, budget and last timestamp cleared,
// configuration registers back to their defaults.
module airtime_duty_cycle_limiter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [adcl_pkg::ReqW-1:0]         in_req_type,
  input  logic [adcl_pkg::TimeW-1:0]        in_now_ms,
  input  logic [adcl_pkg::LenW-1:0]         in_payload_len,
  input  logic                              in_tx_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_granted,
  output logic [adcl_pkg::CreditW-1:0]      out_airtime_q8,
  output logic [adcl_pkg::CreditW-1:0]      out_budget_q8,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adcl_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [adcl_pkg::CreditW-1:0]      cfg_data
);

  adcl_pkg::adcl_cfg_t cfg_r;

  logic                             s1_valid_r;
  logic [adcl_pkg::ReqW-1:0]        s1_req_r;
  logic [adcl_pkg::TimeW-1:0]       s1_now_r;
  logic [adcl_pkg::LenW-1:0]        s1_len_r;
  logic                             s1_ok_r;

  logic [adcl_pkg::CreditW-1:0]     budget_r;
  logic [adcl_pkg::TimeW-1:0]       last_time_r;

  logic                             out_valid_r;
  logic                             out_granted_r;
  logic [adcl_pkg::CreditW-1:0]     out_airtime_r;
  logic [adcl_pkg::CreditW-1:0]     out_budget_r;

  logic                             adv;
  logic                             in_accept;
  logic                             calc_granted;
  logic [adcl_pkg::CreditW-1:0]     calc_airtime;
  logic [adcl_pkg::CreditW-1:0]     budget_nxt;

  // result register free or being drained this cycle
  assign adv       = ~out_valid_r | ~out_stall;
  assign in_stall  = s1_valid_r & ~adv;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refill_per_ms_q8 <= adcl_pkg::RST_REFILL;
      cfg_r.capacity_q8      <= adcl_pkg::RST_CAPACITY;
      cfg_r.preamble_bits    <= adcl_pkg::RST_PREAMBLE;
      cfg_r.overhead_bytes   <= adcl_pkg::RST_OVERHEAD;
      cfg_r.us_per_bit_q8    <= adcl_pkg::RST_BIT_TIME;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        adcl_pkg::REG_REFILL:   cfg_r.refill_per_ms_q8 <= cfg_data[adcl_pkg::RateW-1:0];
        adcl_pkg::REG_CAPACITY: cfg_r.capacity_q8      <= cfg_data;
        adcl_pkg::REG_PREAMBLE: cfg_r.preamble_bits    <= cfg_data[adcl_pkg::PreW-1:0];
        adcl_pkg::REG_OVERHEAD: cfg_r.overhead_bytes   <= cfg_data[adcl_pkg::OvhW-1:0];
        adcl_pkg::REG_BIT_TIME: cfg_r.us_per_bit_q8    <= cfg_data[adcl_pkg::BitTimeW-1:0];
        default: ;
      endcase
    end
  end

  adcl_calc u_calc (
    .cfg          (cfg_r),
    .budget       (budget_r),
    .last_time_ms (last_time_r),
    .req_type     (s1_req_r),
    .now_ms       (s1_now_r),
    .payload_len  (s1_len_r),
    .tx_ok        (s1_ok_r),
    .granted      (calc_granted),
    .airtime_q8   (calc_airtime),
    .budget_nxt   (budget_nxt)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= in_req_type;
      s1_now_r <= in_now_ms;
      s1_len_r <= in_payload_len;
      s1_ok_r  <= in_tx_ok;
    end
  end

  // bucket state moves when the item leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= '0;
      last_time_r <= '0;
    end else if (s1_valid_r && adv) begin
      budget_r    <= budget_nxt;
      last_time_r <= s1_now_r;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      out_granted_r <= calc_granted;
      out_airtime_r <= calc_airtime;
      out_budget_r  <= budget_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted    = out_granted_r;
  assign out_airtime_q8 = out_airtime_r;
  assign out_budget_q8  = out_budget_r;

endmodule

// ===== rtl/adcl_checker.sv =====
`include "airtime_duty_cycle_limiter_assert.svh"

module adcl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_granted,
  input logic [adcl_pkg::CreditW-1:0]      out_airtime_q8,
  input logic [adcl_pkg::CreditW-1:0]      out_budget_q8,
  input logic                              cfg_ready
);

  // a stalled result beat holds
  `ADCL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_budget_q8) && $stable(out_airtime_q8) && $stable(out_granted))

  // input side only backs up when the result register is full
  `ADCL_ASSERT_NOW(a_stall_needs_full, clk, rst_n, in_stall, out_valid)

  // a denied send leaves the budget short of the airtime
  `ADCL_ASSERT_NOW(a_denied_short, clk, rst_n, out_valid && !out_granted && (out_airtime_q8 != '0), out_airtime_q8 > out_budget_q8)

  // result stage drained and input stalled cannot both hold
  `ADCL_ASSERT_NEXT(a_stall_clears, clk, rst_n, in_stall && !out_stall, !in_stall || out_valid)

  `ADCL_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind airtime_duty_cycle_limiter adcl_checker u_adcl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_granted    (out_granted),
  .out_airtime_q8 (out_airtime_q8),
  .out_budget_q8  (out_budget_q8),
  .cfg_ready      (cfg_ready)
);

// ===== test/tb_airtime_duty_cycle_limiter.sv =====
`timescale 1ns / 100ps

module tb_airtime_duty_cycle_limiter;

  localparam int QUIET_LIMIT = 4000;
  // request code 3 is not assigned and behaves as a plain refill
  localparam logic [adcl_pkg::ReqW-1:0] REQ_SPARE = 2'd3;
  localparam logic [adcl_pkg::CfgIdxW-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [adcl_pkg::ReqW-1:0]  req_type;
    logic [adcl_pkg::TimeW-1:0] now_ms;
    logic [adcl_pkg::LenW-1:0]  payload_len;
    logic                       tx_ok;
  } frame_t;

  typedef struct packed {
    logic                         granted;
    logic [adcl_pkg::CreditW-1:0] airtime_q8;
    logic [adcl_pkg::CreditW-1:0] budget_q8;
  } verdict_t;

  typedef struct packed {
    logic     checked;
    verdict_t want;
  } check_note_t;

  typedef struct packed {
    logic                         is_reg;
    logic [adcl_pkg::CfgIdxW-1:0] reg_idx;
    logic [adcl_pkg::CreditW-1:0] reg_data;
    frame_t                       frame;
    logic                         checked;
    verdict_t                     want;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [adcl_pkg::ReqW-1:0]     in_req_type = '0;
  logic [adcl_pkg::TimeW-1:0]    in_now_ms = '0;
  logic [adcl_pkg::LenW-1:0]     in_payload_len = '0;
  logic                          in_tx_ok = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_granted;
  logic [adcl_pkg::CreditW-1:0]  out_airtime_q8;
  logic [adcl_pkg::CreditW-1:0]  out_budget_q8;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [adcl_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [adcl_pkg::CreditW-1:0]  cfg_data = '0;

  // shadow of the limiter
  adcl_pkg::adcl_cfg_t           limits = '{adcl_pkg::RST_REFILL, adcl_pkg::RST_CAPACITY,
                                            adcl_pkg::RST_PREAMBLE, adcl_pkg::RST_OVERHEAD,
                                            adcl_pkg::RST_BIT_TIME};
  logic [adcl_pkg::CreditW-1:0]  credit_q8 = '0;
  logic [adcl_pkg::TimeW-1:0]    last_ms = '0;

  check_note_t                   row_checks [$];
  verdict_t                      verdicts_due [$];
  int                            mismatches = 0;
  int                            quiet = 0;
  int                            send_gap_pct = 34;
  int                            stall_pct = 80;
  logic [adcl_pkg::TimeW-1:0]    stamp_ms = '0;
  plan_row_t                     plan [34];

  airtime_duty_cycle_limiter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_now_ms     (in_now_ms),
    .in_payload_len(in_payload_len),
    .in_tx_ok      (in_tx_ok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_granted   (out_granted),
    .out_airtime_q8(out_airtime_q8),
    .out_budget_q8 (out_budget_q8),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // refill, then grant/charge or restart; updates the shadow state
  function automatic verdict_t grant_verdict(input frame_t f);
    logic [adcl_pkg::TimeW-1:0] gap;
    logic [63:0]                credit;
    logic [63:0]                bits;
    logic [63:0]                air;
    verdict_t                   v;
    gap = f.now_ms - last_ms;
    credit = 64'(credit_q8) + 64'(gap) * 64'(limits.refill_per_ms_q8);
    last_ms = f.now_ms;
    if (credit > 64'(limits.capacity_q8)) credit = 64'(limits.capacity_q8);
    credit_q8 = credit[adcl_pkg::CreditW-1:0];
    v = '0;
    if (f.req_type == adcl_pkg::REQ_SEND) begin
      bits = 64'(limits.preamble_bits) +
             (64'(limits.overhead_bytes) + 64'(f.payload_len)) * 64'd8;
      air = bits * 64'(limits.us_per_bit_q8);
      v.airtime_q8 = air[adcl_pkg::CreditW-1:0];
      if (v.airtime_q8 <= credit_q8) begin
        v.granted = 1'b1;
        if (f.tx_ok) credit_q8 = credit_q8 - v.airtime_q8;
      end
    end else if (f.req_type == adcl_pkg::REQ_RESTART) begin
      credit_q8 = '0;
    end
    v.budget_q8 = credit_q8;
    return v;
  endfunction

  function automatic plan_row_t frame_row(input logic [adcl_pkg::ReqW-1:0] req,
                                          input logic [adcl_pkg::TimeW-1:0] now,
                                          input logic [adcl_pkg::LenW-1:0] len,
                                          input logic ok);
    plan_row_t r;
    r = '0;
    r.frame = '{req, now, len, ok};
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [adcl_pkg::ReqW-1:0] req,
                                          input logic [adcl_pkg::TimeW-1:0] now,
                                          input logic [adcl_pkg::LenW-1:0] len,
                                          input logic ok, input logic g,
                                          input logic [adcl_pkg::CreditW-1:0] air,
                                          input logic [adcl_pkg::CreditW-1:0] bud);
    plan_row_t r;
    r = frame_row(req, now, len, ok);
    r.checked = 1'b1;
    r.want = '{g, air, bud};
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [adcl_pkg::CfgIdxW-1:0] idx,
                                        input logic [adcl_pkg::CreditW-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic int backlog();
    return row_checks.size() + verdicts_due.size();
  endfunction

  task automatic push_frame(input frame_t f, input logic checked, input verdict_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= f.req_type;
    in_now_ms      <= f.now_ms;
    in_payload_len <= f.payload_len;
    in_tx_ok       <= f.tx_ok;
    row_checks.push_back('{checked, want});
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // only with the limiter drained
  task automatic write_reg(input logic [adcl_pkg::CfgIdxW-1:0] idx,
                           input logic [adcl_pkg::CreditW-1:0] data);
    in_valid <= 1'b0;
    while (backlog() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : grant_monitor
    frame_t      f;
    check_note_t note;
    verdict_t    want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          adcl_pkg::REG_REFILL:
            limits.refill_per_ms_q8 = cfg_data[adcl_pkg::RateW-1:0];
          adcl_pkg::REG_CAPACITY: limits.capacity_q8 = cfg_data;
          adcl_pkg::REG_PREAMBLE: limits.preamble_bits = cfg_data[adcl_pkg::PreW-1:0];
          adcl_pkg::REG_OVERHEAD: limits.overhead_bytes = cfg_data[adcl_pkg::OvhW-1:0];
          adcl_pkg::REG_BIT_TIME:
            limits.us_per_bit_q8 = cfg_data[adcl_pkg::BitTimeW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        f = '{in_req_type, in_now_ms, in_payload_len, in_tx_ok};
        note = row_checks.pop_front();
        want = grant_verdict(f);
        verdicts_due.push_back(note.checked ? note.want : want);
      end
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $error("result beat with nothing pending: granted %0d airtime_q8 %0d budget_q8 %0d",
                 out_granted, out_airtime_q8, out_budget_q8);
        end else begin
          want = verdicts_due.pop_front();
          if (out_granted !== want.granted) begin
            mismatches++;
            $error("granted: expected %0d, got %0d", want.granted, out_granted);
          end
          if (out_airtime_q8 !== want.airtime_q8) begin
            mismatches++;
            $error("airtime_q8: expected %0d, got %0d", want.airtime_q8, out_airtime_q8);
          end
          if (out_budget_q8 !== want.budget_q8) begin
            mismatches++;
            $error("budget_q8: expected %0d, got %0d", want.budget_q8, out_budget_q8);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    frame_t              f;
    adcl_pkg::adcl_cfg_t nc;
    logic [63:0]         wide;
    int                  p;

    plan = '{
      known_row(adcl_pkg::REQ_REFILL, 0, 0, 0, 0, 0, 0),
      known_row(adcl_pkg::REQ_SEND, 0, 0, 1, 0, 368640, 0),
      known_row(adcl_pkg::REQ_REFILL, 1000, 0, 0, 0, 0, 2560000),
      known_row(adcl_pkg::REQ_SEND, 1000, 0, 1, 1, 368640, 2191360),
      known_row(adcl_pkg::REQ_SEND, 1000, 255, 1, 0, 10813440, 2191360),
      frame_row(adcl_pkg::REQ_SEND, 1100, 100, 0),
      // long gap saturates at capacity
      known_row(adcl_pkg::REQ_REFILL, 32'hFFFF_FFFF, 0, 0, 0, 0, adcl_pkg::RST_CAPACITY),
      // timestamp wraps
      known_row(adcl_pkg::REQ_REFILL, 5, 0, 0, 0, 0, adcl_pkg::RST_CAPACITY),
      known_row(adcl_pkg::REQ_SEND, 5, 255, 1, 1, 10813440, 40'd9205186560),
      frame_row(adcl_pkg::REQ_SEND, 5, 255, 0),
      frame_row(REQ_SPARE, 6, 7, 1),
      // capacity lowered under the held credit
      reg_row(adcl_pkg::REG_CAPACITY, 40'd5000000),
      known_row(adcl_pkg::REQ_REFILL, 6, 0, 0, 0, 0, 5000000),
      known_row(adcl_pkg::REQ_RESTART, 100, 255, 1, 0, 0, 0),
      known_row(adcl_pkg::REQ_SEND, 100, 0, 1, 0, 368640, 0),
      // zero bit time: free frames
      reg_row(adcl_pkg::REG_BIT_TIME, 40'd0),
      known_row(adcl_pkg::REQ_SEND, 100, 255, 1, 1, 0, 0),
      reg_row(adcl_pkg::REG_CAPACITY, 40'hFF_FFFF_FFFF),
      reg_row(adcl_pkg::REG_REFILL, 40'hFFFF),
      frame_row(adcl_pkg::REQ_REFILL, 32'hFFFF_FFFF, 0, 0),
      reg_row(adcl_pkg::REG_PREAMBLE, 40'hFFFF),
      reg_row(adcl_pkg::REG_OVERHEAD, 40'd31),
      reg_row(adcl_pkg::REG_BIT_TIME, 40'hFFFF),
      frame_row(adcl_pkg::REQ_SEND, 32'hFFFF_FFFF, 255, 1),
      reg_row(REG_SPARE, 40'h55_AAAA_5555),
      reg_row(adcl_pkg::REG_REFILL, 40'd0),
      reg_row(adcl_pkg::REG_PREAMBLE, 40'd0),
      reg_row(adcl_pkg::REG_OVERHEAD, 40'd0),
      reg_row(adcl_pkg::REG_BIT_TIME, 40'd1),
      frame_row(adcl_pkg::REQ_SEND, 0, 0, 1),
      frame_row(adcl_pkg::REQ_SEND, 77, 255, 0),
      reg_row(adcl_pkg::REG_CAPACITY, 40'd0),
      known_row(adcl_pkg::REQ_REFILL, 12345, 0, 0, 0, 0, 0),
      known_row(adcl_pkg::REQ_SEND, 12346, 1, 1, 0, 8, 0)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg)
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      else
        push_frame(plan[i].frame, plan[i].checked, plan[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 34 : (phase == 1) ? 80 : 0;
      stall_pct    = (phase == 0) ? 80 : (phase == 1) ? 34 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        wide = {$urandom, $urandom};
        case (blk % 5)
          0: nc = '{16'($urandom_range(500, 20000)),
                    40'($urandom_range(100000, 50000000)),
                    16'($urandom_range(8, 64)), 5'($urandom), 16'($urandom_range(1, 800))};
          1: nc = '{adcl_pkg::RST_REFILL, adcl_pkg::RST_CAPACITY, adcl_pkg::RST_PREAMBLE,
                    adcl_pkg::RST_OVERHEAD, adcl_pkg::RST_BIT_TIME};
          2: nc = '{16'($urandom), wide[adcl_pkg::CreditW-1:0], 16'($urandom), 5'($urandom),
                    16'($urandom)};
          3: nc = '{16'hFFFF, 40'hFF_FFFF_FFFF, 16'hFFFF, 5'd31, 16'hFFFF};
          default: nc = '{16'($urandom_range(0, 300)), 40'($urandom_range(0, 2000000)),
                          16'($urandom_range(0, 16)), 5'($urandom_range(0, 4)),
                          16'($urandom_range(1, 100))};
        endcase
        write_reg(adcl_pkg::REG_REFILL, 40'(nc.refill_per_ms_q8));
        write_reg(adcl_pkg::REG_CAPACITY, nc.capacity_q8);
        write_reg(adcl_pkg::REG_PREAMBLE, 40'(nc.preamble_bits));
        write_reg(adcl_pkg::REG_OVERHEAD, 40'(nc.overhead_bytes));
        write_reg(adcl_pkg::REG_BIT_TIME, 40'(nc.us_per_bit_q8));
        repeat (97) begin
          p = $urandom_range(99);
          f.req_type = (p < 60) ? adcl_pkg::REQ_SEND : (p < 85) ? adcl_pkg::REQ_REFILL :
                       (p < 95) ? adcl_pkg::REQ_RESTART : REQ_SPARE;
          // mostly short steps forward; sometimes big jumps, backward steps and wraps
          p = $urandom_range(99);
          if (p < 80)      stamp_ms = stamp_ms + 32'($urandom_range(0, 40));
          else if (p < 90) stamp_ms = stamp_ms + 32'($urandom_range(0, 5000));
          else if (p < 95) stamp_ms = 32'($urandom);
          else             stamp_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
          f.now_ms = stamp_ms;
          f.payload_len = 8'($urandom);
          f.tx_ok = 1'($urandom);
          push_frame(f, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (backlog() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    mismatches += verdicts_due.size();
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/adcl_pkg.sv
rtl/adcl_calc.sv
rtl/airtime_duty_cycle_limiter.sv
rtl/adcl_checker.sv
test/tb_airtime_duty_cycle_limiter.sv
